// ----- rtl/nsmc_pkg.sv -----
`default_nettype none
package nsmc_pkg;

  // Field widths
  localparam int ID_W     = 32;
  localparam int DIST_W   = 32;
  localparam int RANK_W   = 6;
  localparam int LIMIT_W  = 7;
  localparam int FRAC_W   = 17;
  localparam int FACTOR_W = 16;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  // Fraction is Q1.16, the cutoff compares distance * count * 256
  localparam int FRAC_SHIFT = 16;
  localparam int SCALE_SH   = 8;

  // Common width for comparing the selection limits
  localparam int CMP_W = 8;

  localparam int MAX_ENTRIES_DEF = 64;

  typedef logic [ID_W-1:0]       id_t;
  typedef logic [DIST_W-1:0]     dist_t;
  typedef logic [RANK_W-1:0]     rank_t;
  typedef logic [LIMIT_W-1:0]    limit_t;
  typedef logic [FRAC_W-1:0]     frac_t;
  typedef logic [FACTOR_W-1:0]   factor_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  // Commands
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SELECT = 1'b1;

  // Register indexes
  localparam cfg_idx_t REG_SELECT_LIMIT    = 2'd0;
  localparam cfg_idx_t REG_SET_FRACTION    = 2'd1;
  localparam cfg_idx_t REG_DISTANCE_FACTOR = 2'd2;

  // Register reset values
  localparam limit_t  SELECT_LIMIT_RST    = 7'd64;
  localparam frac_t   SET_FRACTION_RST    = 17'd65536;
  localparam factor_t DISTANCE_FACTOR_RST = 16'd256;

endpackage
`default_nettype wire

// ----- rtl/nsmc_ifs.sv -----
`default_nettype none
interface nsmc_in_if;
  import nsmc_pkg::*;
  logic  valid;
  logic  ready;
  logic  command;
  id_t   example_id;
  dist_t distance;
  modport source (output valid, command, example_id, distance, input ready);
  modport sink   (input valid, command, example_id, distance, output ready);
endinterface

interface nsmc_out_if;
  import nsmc_pkg::*;
  logic  valid;
  logic  ready;
  id_t   selected_id;
  rank_t rank;
  logic  found;
  logic  overflowed;
  logic  last;
  modport source (output valid, selected_id, rank, found, overflowed, last, input ready);
  modport sink   (input valid, selected_id, rank, found, overflowed, last, output ready);
endinterface

interface nsmc_cfg_if;
  import nsmc_pkg::*;
  logic      valid;
  logic      ready;
  cfg_idx_t  index;
  cfg_data_t data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- rtl/nearest_select_by_mean_cutoff.sv -----
// Loads: one transaction per cycle while idle, stored and summed in the same cycle, no result;
//   a load to a full store only sets the overflow flag. Select over n entries giving k results:
//   each pass reads one entry a cycle from the entry memory (one read port), then multiplies
//   and compares against the cutoff.
// Reset clears the entry count, the distance sum, the overflow flag and the output
//   valid flag, and sets the registers to their defaults. The entry memory is not cleared.
`default_nettype none
module nearest_select_by_mean_cutoff #(
  parameter int MAX_ENTRIES = nsmc_pkg::MAX_ENTRIES_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  nsmc_in_if.sink     in_ch,
  nsmc_out_if.source  out_ch,
  nsmc_cfg_if.sink    cfg_ch
);
  import nsmc_pkg::*;

  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int CW    = $clog2(MAX_ENTRIES + 1);
  localparam int SUM_W = DIST_W + IDX_W;
  localparam int BW    = FACTOR_W + SUM_W;
  localparam int PW    = DIST_W + CW;
  localparam int SP_W  = FRAC_W + CW;
  localparam int ROW_W = ID_W + DIST_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SETUP  = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_MULT   = 3'd3;
  localparam logic [2:0] S_CHECK  = 3'd4;
  localparam logic [2:0] S_FINISH = 3'd5;

  logic [2:0]             state_r;
  logic [CW-1:0]          count_r;
  logic [SUM_W-1:0]       sum_r;
  logic                   ovf_r;
  limit_t                 limit_r;
  frac_t                  frac_r;
  factor_t                factor_r;

  logic [ROW_W-1:0]       mem [MAX_ENTRIES];
  logic [ROW_W-1:0]       rd_q_r;

  logic [CW-1:0]          climit_r;
  logic [BW-1:0]          bound_r;
  logic [CW-1:0]          rank_r;
  logic [MAX_ENTRIES-1:0] taken_r;
  logic [CW-1:0]          issue_r;
  logic                   pend_r;
  logic [IDX_W-1:0]       pend_idx_r;
  logic                   have_r;
  dist_t                  best_d_r;
  id_t                    best_id_r;
  logic [IDX_W-1:0]       best_idx_r;
  logic [PW-1:0]          prod_r;

  logic                   hold_v_r;
  id_t                    hold_id_r;
  logic [CW-1:0]          hold_rank_r;

  logic                   out_valid_r;
  id_t                    out_id_r;
  rank_t                  out_rank_r;
  logic                   out_found_r;
  logic                   out_ovf_r;
  logic                   out_last_r;

  logic                   in_fire;
  logic                   load_fire;
  logic                   mem_we;
  logic                   out_free;
  logic                   issue_go;
  logic                   pend_last;
  logic                   cut_pass;
  logic                   emit_hold;
  logic                   emit_final;
  logic [SP_W-1:0]        share_prod;
  logic [CW:0]            share_c;
  logic [CMP_W-1:0]       cl_c;
  dist_t                  rd_dist;
  id_t                    rd_id;

  // Handshakes; loads and selects are taken only while idle
  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign load_fire    = in_fire && (in_ch.command == CMD_LOAD);
  assign mem_we       = load_fire && (count_r < CW'(MAX_ENTRIES));
  assign out_free     = !out_valid_r || out_ch.ready;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.selected_id = out_id_r;
  assign out_ch.rank        = out_rank_r;
  assign out_ch.found       = out_found_r;
  assign out_ch.overflowed  = out_ovf_r;
  assign out_ch.last        = out_last_r;

  // Selection limit: min(select_limit, floor(fraction * n), n)
  always_comb begin
    share_prod = SP_W'(frac_r) * SP_W'(count_r);
    share_c    = share_prod[SP_W-1:FRAC_SHIFT];
    cl_c       = CMP_W'(count_r);
    if (CMP_W'(share_c) < cl_c) cl_c = CMP_W'(share_c);
    if (CMP_W'(limit_r) < cl_c) cl_c = CMP_W'(limit_r);
  end

  // Scan control and cutoff decision
  assign issue_go   = (state_r == S_SCAN) && (issue_r < count_r);
  assign pend_last  = pend_r && (CW'(pend_idx_r) == count_r - 1'b1);
  assign rd_id      = rd_q_r[ROW_W-1:DIST_W];
  assign rd_dist    = rd_q_r[DIST_W-1:0];
  assign cut_pass   = (BW'(prod_r) << SCALE_SH) <= bound_r;
  assign emit_hold  = (state_r == S_CHECK) && cut_pass && hold_v_r && out_free;
  assign emit_final = (state_r == S_FINISH) && out_free;

  // Entry memory: write on a load that fits, registered read during the scan
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count_r[IDX_W-1:0]] <= {in_ch.example_id, in_ch.distance};
    end
    rd_q_r <= mem[issue_r[IDX_W-1:0]];
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r  <= SELECT_LIMIT_RST;
      frac_r   <= SET_FRACTION_RST;
      factor_r <= DISTANCE_FACTOR_RST;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        REG_SELECT_LIMIT:    limit_r  <= cfg_ch.data[LIMIT_W-1:0];
        REG_SET_FRACTION:    frac_r   <= cfg_ch.data[FRAC_W-1:0];
        REG_DISTANCE_FACTOR: factor_r <= cfg_ch.data[FACTOR_W-1:0];
        default: ;
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      sum_r       <= '0;
      ovf_r       <= 1'b0;
      pend_r      <= 1'b0;
      have_r      <= 1'b0;
      hold_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      rank_r      <= '0;
      issue_r     <= '0;
      taken_r     <= '0;
    end else begin
      // Drain the output register
      if (emit_hold || emit_final) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (mem_we) begin
            count_r <= count_r + 1'b1;
            sum_r   <= sum_r + SUM_W'(in_ch.distance);
          end else if (load_fire) begin
            ovf_r <= 1'b1;
          end
          if (in_fire && (in_ch.command == CMD_SELECT)) begin
            state_r <= S_SETUP;
          end
        end
        S_SETUP: begin
          taken_r  <= '0;
          rank_r   <= '0;
          hold_v_r <= 1'b0;
          issue_r  <= '0;
          pend_r   <= 1'b0;
          have_r   <= 1'b0;
          state_r  <= (cl_c == '0) ? S_FINISH : S_SCAN;
        end
        S_SCAN: begin
          // Issue one read a cycle, fold the returning entry into the minimum
          if (issue_go) issue_r <= issue_r + 1'b1;
          pend_r <= issue_go;
          if (pend_r && !taken_r[pend_idx_r] && (!have_r || rd_dist < best_d_r)) begin
            have_r <= 1'b1;
          end
          if (pend_last) state_r <= S_MULT;
        end
        S_MULT: begin
          state_r <= S_CHECK;
        end
        S_CHECK: begin
          if (!cut_pass) begin
            state_r <= S_FINISH;
          end else if (!hold_v_r || out_free) begin
            taken_r[best_idx_r] <= 1'b1;
            hold_v_r            <= 1'b1;
            rank_r              <= rank_r + 1'b1;
            issue_r             <= '0;
            pend_r              <= 1'b0;
            have_r              <= 1'b0;
            state_r <= (rank_r + 1'b1 == climit_r) ? S_FINISH : S_SCAN;
          end
        end
        S_FINISH: begin
          // Send the final result and clear the store
          if (out_free) begin
            hold_v_r <= 1'b0;
            count_r  <= '0;
            sum_r    <= '0;
            ovf_r    <= 1'b0;
            state_r  <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (state_r == S_SETUP) begin
      climit_r <= cl_c[CW-1:0];
      bound_r  <= BW'(factor_r) * BW'(sum_r);
    end
    if (issue_go) pend_idx_r <= issue_r[IDX_W-1:0];
    if ((state_r == S_SCAN) && pend_r && !taken_r[pend_idx_r]
        && (!have_r || rd_dist < best_d_r)) begin
      best_d_r   <= rd_dist;
      best_id_r  <= rd_id;
      best_idx_r <= pend_idx_r;
    end
    if (state_r == S_MULT) prod_r <= PW'(best_d_r) * PW'(count_r);
    if ((state_r == S_CHECK) && cut_pass && (!hold_v_r || out_free)) begin
      hold_id_r   <= best_id_r;
      hold_rank_r <= rank_r;
    end
    // Load the output register
    if (emit_hold || emit_final) begin
      out_ovf_r <= ovf_r;
      if (hold_v_r) begin
        out_id_r    <= hold_id_r;
        out_rank_r  <= RANK_W'(hold_rank_r);
        out_found_r <= 1'b1;
      end else begin
        out_id_r    <= '0;
        out_rank_r  <= '0;
        out_found_r <= 1'b0;
      end
      out_last_r <= emit_final;
    end
  end

  // Checks
  a_select_setup: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_ch.command == CMD_SELECT) |=> state_r == S_SETUP)
    else $error("select transaction did not start setup");

  a_notfound_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.found |-> out_ch.last)
    else $error("not-found result is not the last one");

  a_taken_rank: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN || state_r == S_MULT || state_r == S_CHECK)
      |-> $countones(taken_r) == int'(rank_r))
    else $error("taken entries disagree with rank");

  a_finish_clears: assert property (@(posedge clk) disable iff (!rst_n)
    emit_final |=> count_r == '0 && state_r == S_IDLE)
    else $error("store not cleared after select");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_ENTRIES))
    else $error("entry count beyond capacity");

endmodule
`default_nettype wire
